[rtl/bb3_pkg.sv]
package bb3_pkg;

	localparam int PIX_W     = 8;
	localparam int ROW_W     = 16;
	localparam int OUT_COL_W = 11;
	localparam int CFG_W     = 12;
	localparam int SUM_W     = 12;
	localparam int COLSUM_W  = 10;

	localparam logic [CFG_W-1:0] WIDTH_RESET = 12'd512;
	localparam logic [CFG_W-1:0] WIDTH_MIN   = 12'd3;

	// floor(x * 7282 / 2^16) == floor(x / 9) for every window sum up to 2295
	localparam int                RECIP_W   = 13;
	localparam logic [RECIP_W-1:0] RECIP9   = 13'd7282;
	localparam int                RECIP_SHR = 16;

	typedef logic [PIX_W-1:0]     pix_t;
	typedef logic [SUM_W-1:0]     sum_t;
	typedef logic [2*PIX_W-1:0]   entry_t;

	typedef struct packed {
		logic [ROW_W-1:0]     row;
		logic [OUT_COL_W-1:0] col;
	} centre_t;

	typedef struct packed {
		sum_t    sum;
		centre_t centre;
	} win_res_t;

endpackage

[rtl/bb3_ram.sv]
module bb3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data until the next read
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/bb3_window.sv]
module bb3_window import bb3_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  entry_t entry,
	input  pix_t   pix,
	input  logic   advance,
	output sum_t   sum,
	output entry_t wr_data
);

	logic [3*PIX_W-1:0]  col0_q, col1_q, current;
	logic [COLSUM_W-1:0] cs0, cs1, cs2;

	function automatic logic [COLSUM_W-1:0] col_sum(input logic [3*PIX_W-1:0] c);
		col_sum = COLSUM_W'(c[3*PIX_W-1:2*PIX_W]) + COLSUM_W'(c[2*PIX_W-1:PIX_W])
			+ COLSUM_W'(c[PIX_W-1:0]);
	endfunction

	// current column: two rows up, one row up, this pixel
	assign current = {entry, pix};
	assign wr_data = {entry[PIX_W-1:0], pix};

	assign cs0 = col_sum(col0_q);
	assign cs1 = col_sum(col1_q);
	assign cs2 = col_sum(current);
	assign sum = SUM_W'(cs0) + SUM_W'(cs1) + SUM_W'(cs2);

	// shift the window once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col0_q <= '0;
			col1_q <= '0;
		end else if (advance) begin
			col0_q <= col1_q;
			col1_q <= current;
		end
	end

endmodule

[rtl/bb3_div9.sv]
module bb3_div9 import bb3_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  win_res_t in_res,
	output logic     out_valid,
	input  logic     out_ready,
	output pix_t     out_value,
	output centre_t  out_centre
);

	logic                       s2_valid_q;
	win_res_t                   res_s2;
	logic [SUM_W+RECIP_W-1:0]   prod;
	logic                       s2_move;

	assign s2_move  = s2_valid_q && (!out_valid || out_ready);
	assign in_ready = !s2_valid_q || s2_move;
	assign prod     = (SUM_W+RECIP_W)'(res_s2.sum) * (SUM_W+RECIP_W)'(RECIP9);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (in_ready) begin
				s2_valid_q <= in_valid;
			end
			if (!out_valid || out_ready) begin
				out_valid <= s2_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_s2 <= in_res;
		end
		if (s2_move) begin
			out_value  <= PIX_W'(prod >> RECIP_SHR);
			out_centre <= res_s2.centre;
		end
	end

endmodule

[rtl/box_blur_3x3_stream.sv]
// Channel   Direction  Handshake           Payload
// --------  ---------  ------------------  ------------------------------------------
// input     in         in_valid/in_ready   pixel_value[7:0], frame_start
// output    out        out_valid/out_ready blurred_value[7:0], centre_row[15:0],
//                                          centre_column[10:0]
// config    in         cfg_write           cfg_data[11:0] (image_width)
//
// One pixel transaction per clock while the output takes results. A result passes the
// window stage, the sum register and the output register: line store read, window sum,
// multiply. The line store is read on accept and written back as the pixel leaves the
// window stage, with the pending write forwarded when the next pixel hits that column.
// Reset clears counters, window and valid flags; the line store needs no clearing.
// A stalled output fills the sum and output registers, then the window stage, and
// only then drops in_ready.
module box_blur_3x3_stream import bb3_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     pixel_value,
	input  logic                 frame_start,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PIX_W-1:0]     blurred_value,
	output logic [ROW_W-1:0]     centre_row,
	output logic [OUT_COL_W-1:0] centre_column
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;

	// configuration and raster counters
	logic [CFG_W-1:0] image_width_q;
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	// window stage
	logic             s1_valid_q;
	logic [CW-1:0]    col_s1;
	logic [ROW_W-1:0] row_s1;
	pix_t             pix_s1;
	logic             res_s1;
	logic             fwd_s1;
	entry_t           fwd_data_s1;

	logic             accept;
	logic             s1_leave;
	logic             s2_ready;
	logic [CW-1:0]    col_s0;
	logic [ROW_W-1:0] row_s0;
	logic [WW-1:0]    width_eff;
	logic [WW-1:0]    col_inc;
	logic             wrap;
	entry_t           rd_entry;
	entry_t           entry_s1;
	entry_t           wr_data;
	sum_t             win_sum;
	win_res_t         win_res;
	centre_t          out_centre;

	// clamp the programmed width to the range the line store supports
	always_comb begin
		if (image_width_q < WIDTH_MIN) begin
			width_eff = WW'(WIDTH_MIN);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			width_eff = WW'(MAX_WIDTH);
		end else begin
			width_eff = WW'(image_width_q);
		end
	end

	// frame_start restarts the raster at row 0, column 0
	assign col_s0  = frame_start ? '0 : col_q;
	assign row_s0  = frame_start ? '0 : row_q;
	assign col_inc = {1'b0, col_s0} + WW'(1);
	assign wrap    = col_inc >= width_eff;

	// the window stage leaves when its result, if any, has room downstream
	assign s1_leave = s1_valid_q && (!res_s1 || s2_ready);
	assign in_ready = !s1_valid_q || s1_leave;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= WIDTH_RESET;
			col_q         <= '0;
			row_q         <= '0;
			s1_valid_q    <= 1'b0;
		end else begin
			if (cfg_write) begin
				image_width_q <= cfg_data;
			end
			if (accept) begin
				col_q <= wrap ? '0 : CW'(col_inc);
				row_q <= wrap ? row_s0 + ROW_W'(1) : row_s0;
			end
			if (in_ready) begin
				s1_valid_q <= in_valid;
			end
		end
	end

	// payload of the window stage; capture the write that lands on the same column
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1      <= col_s0;
			row_s1      <= row_s0;
			pix_s1      <= pixel_value;
			res_s1      <= (row_s0 >= ROW_W'(2)) && (col_s0 >= CW'(2));
			fwd_s1      <= s1_leave && (col_s1 == col_s0);
			fwd_data_s1 <= wr_data;
		end
	end

	// line store: read on accept, write back as the pixel leaves the window stage
	bb3_ram #(
		.WIDTH (2*PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (s1_leave),
		.waddr (col_s1),
		.wdata (wr_data),
		.re    (accept),
		.raddr (col_s0),
		.rdata (rd_entry)
	);

	assign entry_s1 = fwd_s1 ? fwd_data_s1 : rd_entry;

	bb3_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.entry   (entry_s1),
		.pix     (pix_s1),
		.advance (s1_leave),
		.sum     (win_sum),
		.wr_data (wr_data)
	);

	// centre sits one row up and one column left of the current pixel
	assign win_res.sum        = win_sum;
	assign win_res.centre.row = row_s1 - ROW_W'(1);
	assign win_res.centre.col = OUT_COL_W'(col_s1 - CW'(1));

	bb3_div9 u_div9 (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s1_valid_q && res_s1),
		.in_ready   (s2_ready),
		.in_res     (win_res),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_value  (blurred_value),
		.out_centre (out_centre)
	);

	assign centre_row    = out_centre.row;
	assign centre_column = out_centre.col;

endmodule

[test/blur_score_pkg.sv]
package blur_score_pkg;
	import bb3_pkg::*;

	localparam int LINE_DEPTH  = 2048;

	typedef struct packed {
		pix_t                 value;
		logic [ROW_W-1:0]     row;
		logic [OUT_COL_W-1:0] col;
	} blur_out_t;

	class blur_tracker;
		entry_t               line_mem [LINE_DEPTH];
		logic [3*PIX_W-1:0]   prev_cols [2];
		logic [OUT_COL_W-1:0] col_count;
		logic [ROW_W-1:0]     row_count;
		logic [CFG_W-1:0]     width_reg;
		blur_out_t            due_blurs [$];
		int                   errors;

		function new();
			foreach (line_mem[i]) line_mem[i] = '0;
			prev_cols[0] = '0;
			prev_cols[1] = '0;
			col_count    = '0;
			row_count    = '0;
			width_reg    = WIDTH_RESET;
			errors       = 0;
		endfunction

		function int unsigned eff_width(logic [CFG_W-1:0] raw);
			if (raw < WIDTH_MIN) return WIDTH_MIN;
			if (raw > LINE_DEPTH) return LINE_DEPTH;
			return raw;
		endfunction

		function void set_width(logic [CFG_W-1:0] raw);
			width_reg = raw;
		endfunction

		function int count();
			return due_blurs.size();
		endfunction

		function int unsigned col_total(logic [3*PIX_W-1:0] stack);
			return 32'(stack[23:16]) + 32'(stack[15:8]) + 32'(stack[7:0]);
		endfunction

		function void note_pixel(pix_t pix, logic fs);
			int unsigned          c, w, s;
			entry_t               above;
			logic [3*PIX_W-1:0]   now_col;
			blur_out_t            blur;
			w = eff_width(width_reg);
			if (fs) begin
				col_count = '0;
				row_count = '0;
			end
			c       = col_count;
			above   = line_mem[c];
			line_mem[c] = {above[PIX_W-1:0], pix};
			now_col = {above, pix};
			if (row_count >= 2 && c >= 2) begin
				s = col_total(prev_cols[0]) + col_total(prev_cols[1]) + col_total(now_col);
				blur.value = PIX_W'(s / 9);
				blur.row   = row_count - 1'b1;
				blur.col   = OUT_COL_W'(c - 1);
				due_blurs.push_back(blur);
			end
			prev_cols[0] = prev_cols[1];
			prev_cols[1] = now_col;
			c++;
			if (c >= w) begin
				c = 0;
				row_count++;
			end
			col_count = OUT_COL_W'(c);
		endfunction

		function void flag(string what, logic [ROW_W-1:0] want, logic [ROW_W-1:0] got);
			errors++;
			$display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
		endfunction

		function void check_result(pix_t value, logic [ROW_W-1:0] row,
				logic [OUT_COL_W-1:0] col);
			blur_out_t want;
			if (due_blurs.size() == 0) begin
				errors++;
				$display("%0t: result with nothing pending: value %0d, row %0d, column %0d",
					$time, value, row, col);
				return;
			end
			want = due_blurs.pop_front();
			if (value !== want.value)
				flag("blurred_value", ROW_W'(want.value), ROW_W'(value));
			if (row !== want.row)
				flag("centre_row", want.row, row);
			if (col !== want.col)
				flag("centre_column", ROW_W'(want.col), ROW_W'(col));
		endfunction
	endclass

endpackage

[test/box_blur_3x3_stream_test.sv]
module box_blur_3x3_stream_test;
	import bb3_pkg::*;
	import blur_score_pkg::*;

	localparam int RANDOM_ITEMS  = 980;
	// time for pixels to leave the pipe, plus margin
	localparam int SETTLE_CYCLES = 8;
	// a stall burst, a send gap, a config write and the pipe all fit well inside this
	localparam int STALL_LIMIT   = 1000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [PIX_W-1:0]     pixel_value;
	logic                 frame_start;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [PIX_W-1:0]     blurred_value;
	logic [ROW_W-1:0]     centre_row;
	logic [OUT_COL_W-1:0] centre_column;

	blur_tracker tracker;
	bit          idle_on      = 1'b1;
	int unsigned sent_count   = 0;
	int          hold_left    = 0;
	int          quiet_cycles = 0;

	box_blur_3x3_stream #(
		.MAX_WIDTH(LINE_DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_value  (pixel_value),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.blurred_value(blurred_value),
		.centre_row   (centre_row),
		.centre_column(centre_column)
	);

	always #6 clk = ~clk;

	// Offer one pixel transaction and hold it until the block takes it. Valid stays
	// high back to back unless a random gap is drawn first.
	task automatic put_pixel(input pix_t pix, input logic fs);
		int gap;
		if (idle_on && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 15);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		pixel_value <= pix;
		frame_start <= fs;
		do @(posedge clk); while (!in_ready);
		tracker.note_pixel(pix, fs);
		sent_count++;
	endtask

	// Send n pixels, the first one opening a frame if asked. Stray frame starts
	// restart the counters mid-frame; keep them out where a frame must run long.
	task automatic feed_pixels(input int unsigned n, input bit open_frame, input bit stray);
		pix_t pix;
		bit   fs;
		for (int unsigned i = 0; i < n; i++) begin
			case ($urandom_range(0, 7))
				0: pix = '0;
				1: pix = '1;
				default: pix = pix_t'($urandom);
			endcase
			fs = (open_frame && i == 0) || (stray && $urandom_range(0, 199) == 0);
			put_pixel(pix, fs);
		end
	endtask

	// Change the width only with the block idle: drop valid, let every pending
	// result drain, give pixels that make no result time to leave the pipe.
	task automatic write_width(input logic [CFG_W-1:0] raw);
		in_valid <= 1'b0;
		while (tracker.count() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_data  <= raw;
		@(posedge clk);
		cfg_write <= 1'b0;
		tracker.set_width(raw);
	endtask

	// Check every result transaction, then pick the next ready level: random stall
	// bursts while idling is on, ready otherwise.
	always @(posedge clk) begin
		if (out_valid && out_ready)
			tracker.check_result(blurred_value, centre_row, centre_column);
		if (hold_left > 0) begin
			hold_left--;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			hold_left = $urandom_range(1, 15) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Count cycles with no transaction on either channel; a hang ends the run.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int unsigned      goal, span;
		logic [CFG_W-1:0] raw;
		tracker     = new();
		arst_n      = 1'b0;
		cfg_write   = 1'b0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		pixel_value = '0;
		frame_start = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Narrowest frame, straight out of reset with no frame start: a flat
		// bright window, then dark rows fading it, then a frame start mid-row
		// followed by single-bit pixels.
		write_width('0);
		for (int i = 0; i < 9; i++) put_pixel('1, 1'b0);
		repeat (7) put_pixel('0, 1'b0);
		put_pixel(8'h80, 1'b1);
		for (int i = 0; i < 7; i++) put_pixel(pix_t'(1 << i), 1'b0);
		put_pixel('1, 1'b0);

		// Shrink the width mid-row: the stalled column is past the new width, so
		// that pixel still lands at its column before the row wraps.
		write_width(12'd10);
		feed_pixels(36, 1'b1, 1'b0);
		write_width(12'd4);
		feed_pixels(14, 1'b0, 1'b0);

		// Random frames, mostly narrow, some below the minimum, a few wider. Grow
		// the width only with a fresh frame; sometimes shrink part way through.
		goal = sent_count + RANDOM_ITEMS;
		while (sent_count < goal) begin
			case ($urandom_range(0, 9))
				0: raw = CFG_W'($urandom_range(0, 3));
				1: raw = CFG_W'($urandom_range(30, 80));
				default: raw = CFG_W'($urandom_range(3, 16));
			endcase
			write_width(raw);
			span = tracker.eff_width(raw);
			feed_pixels(span * $urandom_range(2, 7) + $urandom_range(0, span - 1), 1'b1, 1'b1);
			if (span > 3 && $urandom_range(0, 2) == 0) begin
				raw = CFG_W'($urandom_range(0, span - 1));
				write_width(raw);
				span = tracker.eff_width(raw);
				feed_pixels(span * $urandom_range(1, 4) + $urandom_range(0, span - 1),
					1'b0, 1'b1);
			end
		end

		// Last part at full rate on both sides: a fresh narrow frame streamed
		// back to back.
		idle_on = 1'b0;
		write_width(WIDTH_MIN);
		feed_pixels(WIDTH_MIN * 16, 1'b1, 1'b0);

		in_valid <= 1'b0;
		while (tracker.count() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[box_blur_3x3_stream.f]
rtl/bb3_pkg.sv
rtl/bb3_ram.sv
rtl/bb3_window.sv
rtl/bb3_div9.sv
rtl/box_blur_3x3_stream.sv
test/blur_score_pkg.sv
test/box_blur_3x3_stream_test.sv
